### design/twcs_pkg.sv
package twcs_pkg;
  localparam int PoolDepth = 32;
  localparam int ProcessCount = 8;
  localparam int LinkW = 6;
  localparam logic [LinkW-1:0] LinkNull = 6'd63;
  localparam int SlotW = 3 + 3 + 1 + 32 + 32 + 32;

  typedef enum logic [1:0] {
    CMD_PUSH = 2'd0,
    CMD_ROLLBACK = 2'd1,
    CMD_COMMIT = 2'd2,
    CMD_INVALID = 2'd3
  } cmd_t;

  typedef struct packed {
    logic [2:0] sender;
    logic [2:0] receiver;
    logic anti;
    logic signed [31:0] tx_stamp;
    logic signed [31:0] rx_stamp;
    logic [31:0] payload;
  } slot_t;
endpackage

### design/twcs_ram.sv
module twcs_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/time_warp_cancellation_store.sv
// Time-warp output queue. Events sit in a 32-slot pool, one newest-first
// list per sender, plus a free list. Assert start while busy is low; the
// block then raises busy and emits results, one strobe-marked cycle each,
// which the receiver must take as they come. Each command ends with one
// status result (last=1). Push, failed push and invalid commands give only
// that result; rollback first emits an anti-message per event it removes,
// and commit walks every process list. Each list step waits on the
// registered-read slot and link memories. After reset the link memory is
// chained by an initialization pass over all 32 entries, during which busy
// stays high.
module time_warp_cancellation_store
  import twcs_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         cmd,
  input  logic [2:0]         src_lp,
  input  logic [2:0]         dst_lp,
  input  logic signed [31:0] tx_stamp,
  input  logic signed [31:0] rx_stamp,
  input  logic [31:0]        payload,
  input  logic               anti_flag,
  output logic               strobe,
  output logic               kind,
  output logic               last,
  output logic               success,
  output logic [2:0]         out_sender,
  output logic [2:0]         out_receiver,
  output logic signed [31:0] out_send_time,
  output logic signed [31:0] out_recv_time,
  output logic [31:0]        out_payload,
  output logic               out_anti,
  output logic [5:0]         lp_count,
  output logic [5:0]         total_count,
  output logic signed [31:0] gvt
);
  localparam int AW = $clog2(PoolDepth);
  localparam int PW = $clog2(ProcessCount);

  typedef enum logic [9:0] {
    S_INIT   = 10'b0000000001,
    S_IDLE   = 10'b0000000010,
    S_DISP   = 10'b0000000100,
    S_RREAD  = 10'b0000001000,
    S_RTEST  = 10'b0000010000,
    S_CHEAD  = 10'b0000100000,
    S_CREAD  = 10'b0001000000,
    S_CTEST  = 10'b0010000000,
    S_STATUS = 10'b0100000000,
    S_PUSH   = 10'b1000000000
  } state_t;

  state_t state;
  logic [AW-1:0] init_cnt;
  logic [1:0] c_cmd;
  logic [2:0] c_snd, c_rcv;
  logic signed [31:0] c_st, c_rt;
  logic [31:0] c_pl;
  logic c_af;
  logic [LinkW-1:0] free_first;
  logic [LinkW-1:0] list_first [ProcessCount];
  logic [5:0] list_count [ProcessCount];
  logic [5:0] pool_count;
  logic [LinkW-1:0] cur, prev;
  logic [PW-1:0] proc;
  logic [5:0] guard;
  logic succ;

  logic s_we, l_we;
  logic [AW-1:0] s_waddr, s_raddr, l_waddr, l_raddr;
  slot_t s_wdata, s_rdata;
  logic [LinkW-1:0] l_wdata, l_rdata;

  twcs_ram #(.Width(SlotW), .Depth(PoolDepth)) u_slot (
    .clk, .we(s_we), .waddr(s_waddr), .wdata(s_wdata), .raddr(s_raddr), .rdata(s_rdata)
  );
  twcs_ram #(.Width(LinkW), .Depth(PoolDepth)) u_link (
    .clk, .we(l_we), .waddr(l_waddr), .wdata(l_wdata), .raddr(l_raddr), .rdata(l_rdata)
  );

  logic okid;
  logic [PW-1:0] sidx;
  logic cur_ok;
  logic gt;
  assign sidx = c_snd[PW-1:0];
  assign okid = ({3'd0, c_snd} < 6'(ProcessCount));
  assign cur_ok = (cur < LinkW'(PoolDepth)) && (guard < 6'(PoolDepth));
  assign gt = s_rdata.tx_stamp > c_st;
  assign busy = (state != S_IDLE);
  assign total_count = pool_count;

  // predecessor relink of a commit step, written in the cycle after it
  logic pl_we;
  logic [AW-1:0] pl_addr;
  logic [LinkW-1:0] pl_data;

  always_comb begin
    s_we = 1'b0;
    s_waddr = free_first[AW-1:0];
    s_wdata = '{c_snd, c_rcv, c_af, c_st, c_rt, c_pl};
    s_raddr = cur[AW-1:0];
    l_we = 1'b0;
    l_waddr = cur[AW-1:0];
    l_wdata = l_rdata;
    l_raddr = cur[AW-1:0];
    unique case (state)
      S_INIT: begin
        l_we = 1'b1;
        l_waddr = init_cnt;
        l_wdata = (init_cnt == AW'(PoolDepth - 1)) ? LinkNull : LinkW'(init_cnt) + 1'b1;
      end
      S_DISP: l_raddr = free_first[AW-1:0];
      S_PUSH: begin
        s_we = 1'b1;
        l_we = 1'b1;
        l_waddr = free_first[AW-1:0];
        l_wdata = list_first[sidx];
      end
      S_RTEST: begin
        if (gt) begin
          l_we = 1'b1;
          l_wdata = free_first;
        end
      end
      S_CTEST: begin
        if (!gt) begin
          l_we = 1'b1;
          l_wdata = free_first;
        end
      end
      default: ;
    endcase
    if (pl_we) begin
      l_we = 1'b1;
      l_waddr = pl_addr;
      l_wdata = pl_data;
    end
  end

  logic ctest_prev_link;
  assign ctest_prev_link = (state == S_CTEST) && !gt && (prev < LinkW'(PoolDepth));

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
      state <= S_INIT;
      init_cnt <= '0;
      free_first <= '0;
      pool_count <= '0;
      gvt <= '0;
      pl_we <= 1'b0;
      for (int i = 0; i < ProcessCount; i++) begin
        list_first[i] <= LinkNull;
        list_count[i] <= '0;
      end
    end else begin
      strobe <= (state == S_STATUS) || ((state == S_RTEST) && gt);
      pl_we <= ctest_prev_link;
      unique case (state)
        S_INIT: begin
          init_cnt <= init_cnt + 1'b1;
          if (init_cnt == AW'(PoolDepth - 1)) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            c_cmd <= cmd; c_snd <= src_lp; c_rcv <= dst_lp;
            c_st <= tx_stamp; c_rt <= rx_stamp; c_pl <= payload;
            c_af <= anti_flag;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          guard <= '0;
          proc <= '0;
          unique case (cmd_t'(c_cmd))
            CMD_PUSH: begin
              succ <= 1'b0;
              state <= (okid && pool_count < 6'(PoolDepth) &&
                        free_first < LinkW'(PoolDepth)) ? S_PUSH : S_STATUS;
            end
            CMD_ROLLBACK: begin
              cur <= list_first[sidx];
              succ <= okid;
              state <= okid ? S_RREAD : S_STATUS;
            end
            CMD_COMMIT: begin
              gvt <= c_st;
              succ <= 1'b1;
              state <= S_CHEAD;
            end
            default: begin
              succ <= 1'b0;
              state <= S_STATUS;
            end
          endcase
        end
        S_PUSH: begin
          free_first <= l_rdata;
          list_first[sidx] <= free_first;
          list_count[sidx] <= list_count[sidx] + 1'b1;
          pool_count <= pool_count + 1'b1;
          succ <= 1'b1;
          state <= S_STATUS;
        end
        S_RREAD: state <= cur_ok ? S_RTEST : S_STATUS;
        S_RTEST: begin
          if (gt) begin
            list_first[sidx] <= l_rdata;
            free_first <= cur;
            if (pool_count != 0) pool_count <= pool_count - 1'b1;
            if (list_count[sidx] != 0) list_count[sidx] <= list_count[sidx] - 1'b1;
            kind <= 1'b1; last <= 1'b0; success <= 1'b1;
            out_sender <= s_rdata.sender; out_receiver <= s_rdata.receiver;
            out_send_time <= s_rdata.tx_stamp; out_recv_time <= s_rdata.rx_stamp;
            out_payload <= s_rdata.payload; out_anti <= 1'b1;
            lp_count <= (list_count[sidx] != 0) ? list_count[sidx] - 1'b1 : 6'd0;
            cur <= l_rdata;
            guard <= guard + 1'b1;
            state <= S_RREAD;
          end else begin
            state <= S_STATUS;
          end
        end
        S_CHEAD: begin
          cur <= list_first[proc];
          prev <= LinkNull;
          guard <= '0;
          state <= S_CREAD;
        end
        S_CREAD: begin
          if (cur_ok) begin
            state <= S_CTEST;
          end else if (proc == PW'(ProcessCount - 1)) begin
            state <= S_STATUS;
          end else begin
            proc <= proc + 1'b1;
            state <= S_CHEAD;
          end
        end
        S_CTEST: begin
          if (!gt) begin
            if (prev >= LinkW'(PoolDepth)) list_first[proc] <= l_rdata;
            else begin
              pl_addr <= prev[AW-1:0];
              pl_data <= l_rdata;
            end
            free_first <= cur;
            if (pool_count != 0) pool_count <= pool_count - 1'b1;
            if (list_count[proc] != 0) list_count[proc] <= list_count[proc] - 1'b1;
          end else begin
            prev <= cur;
          end
          cur <= l_rdata;
          guard <= guard + 1'b1;
          state <= S_CREAD;
        end
        S_STATUS: begin
          kind <= 1'b0; last <= 1'b1; success <= succ;
          out_sender <= c_snd; out_receiver <= c_rcv;
          out_send_time <= c_st; out_recv_time <= c_rt;
          out_payload <= c_pl; out_anti <= c_af;
          lp_count <= okid ? list_count[sidx] : 6'd0;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pool_bound: assert property (@(posedge clk) disable iff (rst)
    pool_count <= 6'(PoolDepth)) else $error("pool count overflow");
  a_status_idle: assert property (@(posedge clk) disable iff (rst)
    (strobe && last) |-> !busy) else $error("status without return to idle");
  a_anti_kind: assert property (@(posedge clk) disable iff (rst)
    (strobe && kind) |-> (out_anti && !last)) else $error("bad anti-message");
`endif
endmodule

### test/tb_time_warp_cancellation_store.sv
module tb_time_warp_cancellation_store;
  import twcs_pkg::*;

  typedef struct {
    logic              kind;
    logic              last;
    logic              success;
    logic [2:0]        snd;
    logic [2:0]        rcv;
    logic signed [31:0] st;
    logic signed [31:0] rt;
    logic [31:0]       pl;
    logic              anti;
    logic [5:0]        lpc;
    logic [5:0]        tot;
    logic signed [31:0] gvt;
  } outcome_t;

  class event_pool_scoreboard;
    logic signed [31:0] ev_send[PoolDepth];
    logic signed [31:0] ev_recv[PoolDepth];
    logic [31:0]        ev_data[PoolDepth];
    logic [2:0]         ev_snd[PoolDepth];
    logic [2:0]         ev_rcv[PoolDepth];
    logic               ev_anti[PoolDepth];
    logic [LinkW-1:0]   next_slot[PoolDepth];
    logic [LinkW-1:0]   free_top;
    logic [LinkW-1:0]   lp_head[ProcessCount];
    int                 lp_cnt[ProcessCount];
    int                 held;
    logic signed [31:0] gvt_now;
    outcome_t           pending[$];
    int                 errors;
    int                 antis_seen;

    function new();
      errors = 0;
      antis_seen = 0;
      for (int i = 0; i < PoolDepth; i++) next_slot[i] = LinkW'(i + 1);
      next_slot[PoolDepth-1] = LinkNull;
      free_top = '0;
      for (int p = 0; p < ProcessCount; p++) begin
        lp_head[p] = LinkNull;
        lp_cnt[p] = 0;
      end
      held = 0;
      gvt_now = '0;
    endfunction

    function void free_slot(int s);
      next_slot[s] = free_top;
      free_top = LinkW'(s);
      if (held > 0) held--;
    endfunction

    function void note(cmd_t c, logic [2:0] s, logic [2:0] r, logic signed [31:0] st,
                       logic signed [31:0] rt, logic [31:0] pl, logic af);
      outcome_t o;
      logic ok;
      int cur, prev, nxt, guard;
      ok = 1'b0;
      case (c)
        CMD_PUSH: begin
          if (held < PoolDepth && free_top < PoolDepth) begin
            cur = free_top;
            free_top = next_slot[cur];
            ev_send[cur] = st; ev_recv[cur] = rt; ev_data[cur] = pl;
            ev_snd[cur] = s; ev_rcv[cur] = r; ev_anti[cur] = af;
            next_slot[cur] = lp_head[s];
            lp_head[s] = LinkW'(cur);
            lp_cnt[s]++;
            held++;
            ok = 1'b1;
          end
        end
        CMD_ROLLBACK: begin
          cur = lp_head[s];
          guard = 0;
          while (cur < PoolDepth && guard < PoolDepth && ev_send[cur] > st) begin
            nxt = next_slot[cur];
            lp_head[s] = LinkW'(nxt);
            free_slot(cur);
            if (lp_cnt[s] > 0) lp_cnt[s]--;
            o = '{1'b1, 1'b0, 1'b1, ev_snd[cur], ev_rcv[cur], ev_send[cur], ev_recv[cur],
                  ev_data[cur], 1'b1, 6'(lp_cnt[s]), 6'(held), gvt_now};
            pending.push_back(o);
            cur = nxt;
            guard++;
          end
          ok = 1'b1;
        end
        CMD_COMMIT: begin
          gvt_now = st;
          for (int p = 0; p < ProcessCount; p++) begin
            prev = LinkNull;
            cur = lp_head[p];
            guard = 0;
            while (cur < PoolDepth && guard < PoolDepth) begin
              nxt = next_slot[cur];
              if (ev_send[cur] <= st) begin
                if (prev >= PoolDepth) lp_head[p] = LinkW'(nxt);
                else next_slot[prev] = LinkW'(nxt);
                free_slot(cur);
                if (lp_cnt[p] > 0) lp_cnt[p]--;
              end else begin
                prev = cur;
              end
              cur = nxt;
              guard++;
            end
          end
          ok = 1'b1;
        end
        default: ok = 1'b0;
      endcase
      o = '{1'b0, 1'b1, ok, s, r, st, rt, pl, af, 6'(lp_cnt[s]), 6'(held), gvt_now};
      pending.push_back(o);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
      errors++;
    endtask

    task check(outcome_t g);
      outcome_t e;
      if (pending.size() == 0) begin
        report("unexpected result", 32'(g.kind), 32'hffff_ffff);
      end else begin
        e = pending.pop_front();
        if (g.kind) antis_seen++;
        if (g.kind !== e.kind) report("kind", 32'(g.kind), 32'(e.kind));
        if (g.last !== e.last) report("last", 32'(g.last), 32'(e.last));
        if (g.success !== e.success) report("success", 32'(g.success), 32'(e.success));
        if (g.snd !== e.snd) report("out_sender", 32'(g.snd), 32'(e.snd));
        if (g.rcv !== e.rcv) report("out_receiver", 32'(g.rcv), 32'(e.rcv));
        if (g.st !== e.st) report("out_send_time", g.st, e.st);
        if (g.rt !== e.rt) report("out_recv_time", g.rt, e.rt);
        if (g.pl !== e.pl) report("out_payload", g.pl, e.pl);
        if (g.anti !== e.anti) report("out_anti", 32'(g.anti), 32'(e.anti));
        if (g.lpc !== e.lpc) report("lp_count", 32'(g.lpc), 32'(e.lpc));
        if (g.tot !== e.tot) report("total_count", 32'(g.tot), 32'(e.tot));
        if (g.gvt !== e.gvt) report("gvt", g.gvt, e.gvt);
      end
    endtask
  endclass

  logic clk, rst, start, busy;
  logic [1:0] cmd;
  logic [2:0] src_lp, dst_lp;
  logic signed [31:0] tx_stamp, rx_stamp;
  logic [31:0] payload;
  logic anti_flag;
  logic strobe, kind, last, success, out_anti;
  logic [2:0] out_sender, out_receiver;
  logic signed [31:0] out_send_time, out_recv_time, gvt;
  logic [31:0] out_payload;
  logic [5:0] lp_count, total_count;

  time_warp_cancellation_store dut (.*);

  event_pool_scoreboard sb;
  int cycles = 0;
  int idle_pct = 0;
  int op_tally[4];
  localparam int CycleLimit = 400000;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) begin
        sb.note(cmd_t'(cmd), src_lp, dst_lp, tx_stamp, rx_stamp, payload,
                anti_flag);
        op_tally[cmd]++;
      end
      if (strobe)
        sb.check('{kind, last, success, out_sender, out_receiver, out_send_time,
                   out_recv_time, out_payload, out_anti, lp_count, total_count, gvt});
    end
  end

  task send(cmd_t c, logic [2:0] s, logic signed [31:0] st);
    while ($urandom_range(99) < idle_pct) @(negedge clk);
    while (busy) @(negedge clk);
    cmd = c;
    src_lp = s;
    dst_lp = 3'($urandom);
    tx_stamp = st;
    rx_stamp = $urandom;
    payload = $urandom;
    anti_flag = 1'($urandom);
    start = 1'b1;
    @(negedge clk);
    start = 1'b0;
  endtask

  function automatic logic signed [31:0] pick_time();
    int r;
    r = $urandom_range(99);
    if (r < 85) return $signed($urandom_range(200)) - 100;
    if (r < 90) return 32'sh7fff_ffff;
    if (r < 95) return 32'sh8000_0000;
    return $urandom;
  endfunction

  task random_item();
    int r;
    r = $urandom_range(99);
    if (r < 55) send(CMD_PUSH, 3'($urandom), pick_time());
    else if (r < 78) send(CMD_ROLLBACK, 3'($urandom), pick_time());
    else if (r < 93) send(CMD_COMMIT, 3'($urandom), pick_time() - 60);
    else send(CMD_INVALID, 3'($urandom), $urandom);
  endtask

  initial begin
    sb = new();
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_PUSH;
    src_lp = '0;
    dst_lp = '0;
    tx_stamp = '0;
    rx_stamp = '0;
    payload = '0;
    anti_flag = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: extremes, every command, empty rollback, full pool
    send(CMD_ROLLBACK, 3'd0, 32'sh8000_0000);
    send(CMD_PUSH, 3'd0, 32'sh7fff_ffff);
    send(CMD_PUSH, 3'd7, 32'sh8000_0000);
    send(CMD_PUSH, 3'd0, 32'sd5);
    send(CMD_PUSH, 3'd0, 32'sd10);
    send(CMD_ROLLBACK, 3'd0, 32'sd7);
    send(CMD_ROLLBACK, 3'd7, 32'sh8000_0000);
    send(CMD_INVALID, 3'd3, 32'shffff_ffff);
    send(CMD_COMMIT, 3'd0, 32'sd6);
    send(CMD_COMMIT, 3'd7, 32'sh7fff_ffff);
    for (int i = 0; i < PoolDepth + 2; i++)
      send(CMD_PUSH, 3'($urandom), $signed($urandom_range(100)));
    send(CMD_ROLLBACK, 3'd2, 32'sh8000_0000);
    send(CMD_COMMIT, 3'd1, 32'sh7fff_ffff);

    for (int ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 12 : (ph == 1) ? 52 : 0;
      for (int i = 0; i < 10; i++) random_item();
      // fill then unwind a single sender deeply
      for (int i = 0; i < 8; i++) send(CMD_PUSH, 3'd4, $signed($urandom_range(100)));
      send(CMD_ROLLBACK, 3'd4, 32'sd20);
    end
    send(CMD_COMMIT, 3'd0, 32'sh7fff_ffff);

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("ran %0d pushes, %0d rollbacks, %0d commits, %0d invalid commands",
             op_tally[0], op_tally[1], op_tally[2], op_tally[3]);
    $display("checked %0d anti-messages, including full-pool and extreme times",
             sb.antis_seen);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
